// File: hdl/sbfp_pkg.sv
// Shared types and constants for the sample batch frame parser.
// No dependencies; imported by every module in hdl/.
package sbfp_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam logic [3:0] SAMPLE_LAST_OFFSET = 4'd9;   // tenth byte of a sample
    localparam logic [9:0] POS_LAST = 10'h3FF;          // frame byte position before it wraps

    // Configuration register indexes
    localparam logic CFG_MARKER   = 1'b0;
    localparam logic CFG_EXPECTED = 1'b1;

    // Result kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CNT_LO,
        PH_CNT_HI,
        PH_SEQ_LO,
        PH_SEQ_HI,
        PH_FLAGS,
        PH_SAMPLE,
        PH_WRAP
    } phase_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic [15:0]        sequence_res;
        logic [7:0]         frame_flags;
        logic [5:0]         sample_index;
        logic signed [15:0] raw_value;
        logic signed [23:0] analog_value;
        logic signed [23:0] digital_value;
        logic [7:0]         gain_code;
        logic [7:0]         sample_status;
        logic               last;
        logic [31:0]        good_frames;
        logic [31:0]        bad_frames;
    } out_item_t;

endpackage

// File: hdl/sbfp_out_stage.sv
// Result register with valid/ready toward the consumer.
// Depends on sbfp_pkg (out_item_t).
module sbfp_out_stage
    import sbfp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  out_item_t load_data,
    output logic      space,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t data_reg;

    // Free when empty or being drained this cycle
    assign space = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: hdl/sample_batch_frame_parser_core.sv
// Sample batch frame parser, top level.
// Depends on sbfp_pkg and sbfp_out_stage.
//
// Takes one frame byte per transfer; frame_start flags a frame's first byte. The header
// (marker, LE 16-bit sample count, LE 16-bit sequence, flag byte) is checked against
// marker_reg and expected_reg; a mismatch gives one reject result (kind 1) and the
// rest of the frame is dropped. Each following 10-byte sample comes out as one result on
// its tenth byte, the final one with last set. A new frame_start mid-frame drops the
// partial frame silently. Throughput is one byte per clock: each byte is decoded by a
// single level of logic from the frame state into a one-entry result register, and input
// ready only drops while that register holds a result the consumer has not yet taken.
// out_valid rises in the cycle after the tenth sample byte is taken. Configuration writes
// (cfg_we, cfg_index, cfg_data) take effect at once; write only while idle. The frame
// byte position is 10 bits: a frame that never reaches its last sample (count register
// raised past the maximum mid-frame) wraps at 1024 and parses the next bytes as a header.
module sample_batch_frame_parser_core
    import sbfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // byte input
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    // result output
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    // configuration
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    // Configuration registers
    logic [7:0] marker_reg;
    logic [6:0] expected_reg;

    // Frame state
    phase_t      phase_reg, phase_next;
    logic [9:0]  pos_reg, pos_next;           // byte position in the frame, wraps at 1024
    logic [7:0]  count_lo_reg, count_lo_next;
    logic [7:0]  seq_lo_reg, seq_lo_next;
    logic [7:0]  seq_hi_reg, seq_hi_next;
    logic [7:0]  flags_reg, flags_next;
    logic [3:0]  offset_reg, offset_next;     // byte within the current sample, 0..9
    logic [5:0]  sample_cnt_reg, sample_cnt_next;
    logic [31:0] good_reg, good_next;
    logic [31:0] bad_reg, bad_next;
    logic [7:0]  hold_reg [9];                // sample bytes, oldest at 0

    logic      in_fire;
    logic      space;
    logic      res_valid;
    out_item_t res;

    logic [7:0] b;
    logic       start;
    logic       marker_bad;
    logic       count_bad;
    logic       is_last;
    logic       sample_done;

    assign in_ready = space;
    assign in_fire  = in_valid && in_ready;
    assign b        = in_data.rx_byte;
    assign start    = in_data.frame_start;

    assign marker_bad = (b != marker_reg);
    assign count_bad  = (expected_reg == 7'd0)
                     || (expected_reg > 7'(MAX_SAMPLES))
                     || ({b, count_lo_reg} != {9'd0, expected_reg});
    assign is_last     = ({1'b0, sample_cnt_reg} + 7'd1) >= expected_reg;
    // a start byte never completes a sample
    assign sample_done = (phase_reg == PH_SAMPLE) && (offset_reg == SAMPLE_LAST_OFFSET)
                      && !start;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg   <= 8'd0;
            expected_reg <= 7'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MARKER:   marker_reg   <= cfg_data;
                CFG_EXPECTED: expected_reg <= cfg_data[6:0];
                default:      ;
            endcase
        end
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (in_fire)
        begin
            if (start)
            begin
                phase_next = marker_bad ? PH_IDLE : PH_CNT_LO;
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:   phase_next = PH_IDLE;
                    PH_CNT_LO: phase_next = PH_CNT_HI;
                    PH_CNT_HI: phase_next = count_bad ? PH_IDLE : PH_SEQ_LO;
                    PH_SEQ_LO: phase_next = PH_SEQ_HI;
                    PH_SEQ_HI: phase_next = PH_FLAGS;
                    PH_FLAGS:  phase_next = PH_SAMPLE;
                    PH_SAMPLE:
                    begin
                        if (sample_done && is_last)
                        begin
                            phase_next = PH_IDLE;
                        end
                        else if (pos_reg == POS_LAST)
                        begin
                            phase_next = PH_WRAP;
                        end
                        else
                        begin
                            phase_next = PH_SAMPLE;
                        end
                    end
                    PH_WRAP:   phase_next = PH_CNT_LO;
                    default:   phase_next = PH_IDLE;
                endcase
            end
        end
    end

    // Datapath updates and result
    always_comb
    begin
        pos_next        = pos_reg;
        count_lo_next   = count_lo_reg;
        seq_lo_next     = seq_lo_reg;
        seq_hi_next     = seq_hi_reg;
        flags_next      = flags_reg;
        offset_next     = offset_reg;
        sample_cnt_next = sample_cnt_reg;
        good_next       = good_reg;
        bad_next        = bad_reg;
        res_valid       = 1'b0;
        res             = '0;

        if (in_fire)
        begin
            if (start)
            begin
                pos_next        = 10'd1;
                offset_next     = 4'd0;
                sample_cnt_next = 6'd0;
                if (marker_bad)
                begin
                    bad_next  = bad_reg + 32'd1;
                    res_valid = 1'b1;
                end
            end
            else
            begin
                if (phase_reg != PH_IDLE)
                begin
                    pos_next = pos_reg + 10'd1;
                end
                unique case (phase_reg)
                    PH_CNT_LO: count_lo_next = b;
                    PH_CNT_HI:
                    begin
                        if (count_bad)
                        begin
                            bad_next  = bad_reg + 32'd1;
                            res_valid = 1'b1;
                        end
                    end
                    PH_SEQ_LO: seq_lo_next = b;
                    PH_SEQ_HI: seq_hi_next = b;
                    PH_FLAGS:
                    begin
                        flags_next  = b;
                        offset_next = 4'd0;
                    end
                    PH_SAMPLE:
                    begin
                        if (sample_done)
                        begin
                            offset_next     = 4'd0;
                            sample_cnt_next = sample_cnt_reg + 6'd1;
                            if (is_last)
                            begin
                                good_next = good_reg + 32'd1;
                            end
                            res_valid = 1'b1;
                        end
                        else
                        begin
                            offset_next = offset_reg + 4'd1;
                        end
                    end
                    // position 0 after a wrap lands on the flag byte slot
                    PH_WRAP:   flags_next = b;
                    default: ;
                endcase
            end
        end

        // Reject: everything but kind and counters stays zero
        if (res_valid && !sample_done)
        begin
            res.kind        = KIND_REJECT;
            res.good_frames = good_next;
            res.bad_frames  = bad_next;
        end
        else if (res_valid)
        begin
            res.kind          = KIND_SAMPLE;
            res.sequence_res  = {seq_hi_reg, seq_lo_reg};
            res.frame_flags   = flags_reg;
            res.sample_index  = sample_cnt_reg;
            res.raw_value     = {hold_reg[1], hold_reg[0]};
            res.analog_value  = {hold_reg[4], hold_reg[3], hold_reg[2]};
            res.digital_value = {hold_reg[7], hold_reg[6], hold_reg[5]};
            res.gain_code     = hold_reg[8];
            res.sample_status = b;
            res.last          = is_last;
            res.good_frames   = good_next;
            res.bad_frames    = bad_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            pos_reg        <= 10'd0;
            count_lo_reg   <= 8'd0;
            seq_lo_reg     <= 8'd0;
            seq_hi_reg     <= 8'd0;
            flags_reg      <= 8'd0;
            offset_reg     <= 4'd0;
            sample_cnt_reg <= 6'd0;
            good_reg       <= 32'd0;
            bad_reg        <= 32'd0;
        end
        else
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            count_lo_reg   <= count_lo_next;
            seq_lo_reg     <= seq_lo_next;
            seq_hi_reg     <= seq_hi_next;
            flags_reg      <= flags_next;
            offset_reg     <= offset_next;
            sample_cnt_reg <= sample_cnt_next;
            good_reg       <= good_next;
            bad_reg        <= bad_next;
        end
    end

    // Sample bytes shift in; after nine, hold_reg[0] is the sample's first byte
    always_ff @(posedge clk)
    begin
        if (in_fire && !start && (phase_reg == PH_SAMPLE) && !sample_done)
        begin
            for (int i = 0; i < 8; i++)
            begin
                hold_reg[i] <= hold_reg[i + 1];
            end
            hold_reg[8] <= b;
        end
    end

    sbfp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_fire && res_valid),
        .load_data (res),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Sample byte offset never leaves 0..9
    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        offset_reg <= SAMPLE_LAST_OFFSET)
        else $error("sample byte offset out of range");

    // A pending result blocks new bytes
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("byte accepted while result register full");

    // Reject counter advances by one on each accepted reject result
    a_bad_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && res_valid && res.kind == KIND_REJECT) |=> (bad_reg == $past(bad_reg) + 32'd1))
        else $error("reject counter did not advance");

    // Final sample closes the frame
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !start && sample_done && is_last) |=> (phase_reg == PH_IDLE))
        else $error("frame still active after last sample");

endmodule
